/* src/timestamped_session_table_defines.svh */
// assertion macros for the session table rtl
`ifndef TIMESTAMPED_SESSION_TABLE_DEFINES_SVH
`define TIMESTAMPED_SESSION_TABLE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define TST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/tst_pkg.sv */
// shared types and constants for the timestamped session table
`timescale 1ns / 1ps

package tst_pkg;

    localparam logic [31:0] MAX_AGE_RESET = 32'd86400;
    localparam logic [31:0] GEN_RESET     = 32'd1;

    localparam logic KIND_PUT     = 1'b0;
    localparam logic KIND_RESTORE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_WRITE
    } tst_state_t;

    // contents of one table entry besides its id
    typedef struct packed {
        logic [31:0]        stamp;
        logic [31:0]        clock;
        logic [7:0]         state;
        logic signed [15:0] pred;
        logic [31:0]        seq;
    } slot_data_t;

    // command broadcast from the controller to every cell
    typedef struct packed {
        logic [15:0] key;
        logic        lookup;
        logic        upd;
        logic        alloc;
        slot_data_t  data;
    } cell_cmd_t;

endpackage

/* src/tst_cell.sv */
// one table entry: id compare, hit data pass-through and fill-order allocation
`timescale 1ns / 1ps

module tst_cell
    import tst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_cmd_t  cmd,
    input  logic       prev_valid,
    input  slot_data_t data_in,
    output slot_data_t data_out,
    output logic       valid,
    output logic       hit
);

    logic        valid_reg;
    logic        hit_reg;
    logic [15:0] id_reg;
    slot_data_t  data_reg;
    logic        hit_now;
    logic        take_alloc;

    // compare against the broadcast key
    assign hit_now    = valid_reg && (id_reg == cmd.key);
    // the first empty cell after the filled run takes a new id
    assign take_alloc = cmd.alloc && !valid_reg && prev_valid;

    // matching cell replaces the data coming down the chain
    assign data_out = hit_now ? data_reg : data_in;
    assign valid    = valid_reg;
    assign hit      = hit_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.lookup)
            begin
                hit_reg <= hit_now;
            end
            if (take_alloc)
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        if (take_alloc)
        begin
            id_reg   <= cmd.key;
            data_reg <= cmd.data;
        end
        else if (cmd.upd && hit_reg)
        begin
            data_reg <= cmd.data;
        end
    end

endmodule

/* src/timestamped_session_table.sv */
// top level of the timestamped session table
`timescale 1ns / 1ps

`include "timestamped_session_table_defines.svh"

// Session table keyed by sensor id, built as a row of SLOTS cells. An item
// is taken when start is high and busy is low, and passes through a lookup
// state in which every cell compares its id with the key and the hit
// entry passes down the row, then a write state in which the controller
// computes the answer and updates the hit or newly filled cell. busy is high
// only in the lookup state, so start may be held through the write state and
// the next item is taken there. The result appears on the cycle after
// the write state, marked by done for exactly one cycle; it cannot be held
// off, so the receiver must take it then. cfg_ready is always high; write
// max_age only while no item is in flight.

module timestamped_session_table
    import tst_pkg::*;
#(
    parameter int SLOTS = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    // item transfer
    input  logic               start,
    output logic               busy,
    input  logic               kind,
    input  logic [15:0]        id,
    input  logic [31:0]        now,
    input  logic               live,
    input  logic [31:0]        session_clock,
    input  logic [7:0]         session_state,
    input  logic signed [15:0] prediction,
    input  logic [31:0]        seq_number,
    // configuration transfer
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_data,
    // result transfer
    output logic               done,
    output logic               restored,
    output logic [31:0]        projected_clock,
    output logic [7:0]         out_state,
    output logic signed [15:0] out_prediction,
    output logic [31:0]        out_sequence,
    output logic               changed,
    output logic               table_full,
    output logic [31:0]        generation
);

    tst_state_t state_reg;
    tst_state_t state_next;

    logic [31:0] max_age_reg;
    logic [31:0] gen_reg;
    logic        done_reg;
    logic        accept;

    // captured item
    logic               kind_reg;
    logic [15:0]        id_reg;
    logic [31:0]        now_reg;
    logic               live_reg;
    logic [31:0]        sclk_reg;
    logic [7:0]         sst_reg;
    logic signed [15:0] spred_reg;
    logic [31:0]        sseq_reg;

    // lookup results
    logic       found;
    slot_data_t fdata_reg;

    // row of cells
    cell_cmd_t        cmd;
    slot_data_t       chain [SLOTS+1];
    logic [SLOTS-1:0] valid_vec;
    logic [SLOTS-1:0] hit_vec;
    logic [SLOTS-1:0] prev_vec;

    // write-cycle logic
    logic        key_ok;
    logic        put_ok;
    logic        alloc_ok;
    logic        differs;
    logic        chg;
    logic        full;
    logic        rs_ok;
    logic [31:0] age;
    logic [31:0] proj;
    slot_data_t  cur;
    slot_data_t  wdata;

    // result registers
    logic               restored_reg;
    logic [31:0]        proj_reg;
    logic [7:0]         ost_reg;
    logic signed [15:0] opred_reg;
    logic [31:0]        oseq_reg;
    logic               changed_reg;
    logic               full_reg;
    logic [31:0]        genout_reg;

    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    // cell hit flags are held from the lookup cycle through the write cycle
    assign found = |hit_vec;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                state_next = start ? ST_LOOKUP : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        busy = 1'b0;
        case (state_reg)
            ST_LOOKUP:
            begin
                busy = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            max_age_reg <= MAX_AGE_RESET;
            gen_reg     <= GEN_RESET;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_WRITE);
            if (cfg_valid && cfg_ready)
            begin
                max_age_reg <= cfg_data;
            end
            if (state_reg == ST_WRITE && chg)
            begin
                gen_reg <= gen_reg + 32'd1;
            end
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= kind;
            id_reg    <= id;
            now_reg   <= now;
            live_reg  <= live;
            sclk_reg  <= session_clock;
            sst_reg   <= session_state;
            spred_reg <= prediction;
            sseq_reg  <= seq_number;
        end
        if (state_reg == ST_LOOKUP)
        begin
            fdata_reg <= chain[SLOTS];
        end
    end

    // broadcast command to the cells
    always_comb
    begin
        cmd        = '0;
        cmd.key    = id_reg;
        cmd.lookup = (state_reg == ST_LOOKUP);
        cmd.upd    = (state_reg == ST_WRITE) && chg && found;
        cmd.alloc  = (state_reg == ST_WRITE) && alloc_ok;
        cmd.data   = wdata;
    end

    // row of cells, hit data handed from cell to cell
    assign chain[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                assign prev_vec[gi] = 1'b1;
            end
            else
            begin : g_rest
                assign prev_vec[gi] = valid_vec[gi-1];
            end

            tst_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .prev_valid (prev_vec[gi]),
                .data_in    (chain[gi]),
                .data_out   (chain[gi+1]),
                .valid      (valid_vec[gi]),
                .hit        (hit_vec[gi])
            );
        end
    endgenerate

    // put: compare with the stored entry, allocate when absent and room left
    always_comb
    begin
        key_ok   = (id_reg != 16'd0);
        put_ok   = (kind_reg == KIND_PUT) && key_ok && live_reg;
        alloc_ok = put_ok && !found && !valid_vec[SLOTS-1];
        full     = put_ok && !found && valid_vec[SLOTS-1];
        cur      = found ? fdata_reg : '0;
        differs  = (cur.clock != sclk_reg) || (cur.state != sst_reg) ||
                   (cur.pred != spred_reg);
        chg      = put_ok && (found || alloc_ok) && differs;

        wdata       = '0;
        wdata.stamp = chg ? now_reg : 32'd0;
        wdata.clock = sclk_reg;
        wdata.state = sst_reg;
        wdata.pred  = spred_reg;
        wdata.seq   = chg ? sseq_reg : 32'd0;
    end

    // restore: age check and forward projection
    always_comb
    begin
        age   = now_reg - fdata_reg.stamp;
        proj  = fdata_reg.clock + age;
        rs_ok = (kind_reg == KIND_RESTORE) && key_ok && found &&
                (fdata_reg.stamp != 32'd0) && (fdata_reg.clock != 32'd0) &&
                (now_reg >= fdata_reg.stamp) && (age <= max_age_reg);
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WRITE)
        begin
            restored_reg <= rs_ok;
            proj_reg     <= rs_ok ? proj : 32'd0;
            ost_reg      <= rs_ok ? fdata_reg.state : 8'd0;
            opred_reg    <= rs_ok ? fdata_reg.pred : 16'sd0;
            oseq_reg     <= rs_ok ? fdata_reg.seq : 32'd0;
            changed_reg  <= chg;
            full_reg     <= full;
            genout_reg   <= chg ? gen_reg + 32'd1 : gen_reg;
        end
    end

    assign done            = done_reg;
    assign restored        = restored_reg;
    assign projected_clock = proj_reg;
    assign out_state       = ost_reg;
    assign out_prediction  = opred_reg;
    assign out_sequence    = oseq_reg;
    assign changed         = changed_reg;
    assign table_full      = full_reg;
    assign generation      = genout_reg;

    `TST_ASSERT_NEXT(a_write_done, state_reg == ST_WRITE, done_reg, "write cycle gave no result")
    `TST_ASSERT_NOW(a_done_src, done_reg, $past(state_reg == ST_WRITE), "result without write")
    `TST_ASSERT_NOW(a_one_hit, state_reg == ST_WRITE, $onehot0(hit_vec), "id held twice")
    `TST_ASSERT_NOW(a_fill_order, 1'b1, (valid_vec & (valid_vec + 1'b1)) == '0, "fill order")
    `TST_ASSERT_NOW(a_flags, done_reg, !(changed_reg && (full_reg || restored_reg)), "flag clash")

endmodule
